// ===== sv/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types, constants and helpers for the min/max stack.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VAL_W       = 31;
    localparam int FILL_W      = 6;
    localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW          = $clog2(STACK_DEPTH + 1);

    localparam logic [VAL_W-1:0] EMPTY_MIN = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] EMPTY_MAX = '0;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_req             req_type;
        logic [VAL_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  read_value;
        logic [FILL_W-1:0] fill_count;
        logic [VAL_W-1:0]  min_value;
        logic [VAL_W-1:0]  max_value;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_EXEC = 3'd1,
        S_TOP  = 3'd2,
        S_SCAN = 3'd3,
        S_FIN  = 3'd4,
        S_DONE = 3'd5
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic take_top;
        logic scan_issue;
        logic scan_fin;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic empty;
        logic top_extreme;
        logic scan_more;
    } t_dp_stat;

    // low bits of the count, whatever the count width
    function automatic logic [FILL_W-1:0] f_fill(input logic [CW-1:0] cnt);
        logic [63:0] w;
        w = 64'(cnt);
        return w[FILL_W-1:0];
    endfunction

endpackage

// ===== sv/stack_with_min_max.sv =====
// ----------------------------------------------------------------------------
// stack_with_min_max
// Bounded LIFO that also reports the smallest and largest value it holds.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Input channel (i_in_valid / o_in_ready / i_in_req) carries one request:
//    push, pop, peek at the top, or clear. Output channel (o_out_valid /
//    i_out_ready / o_out_res) returns exactly one result per request: status,
//    value read, fill count, current minimum and maximum.
//  - One request at a time. Push, clear and any refused request are executed
//    and go straight to the result step. Peek, and a pop that leaves min/max
//    intact, also read the top entry. A pop that removes the current minimum
//    or maximum rescans the remaining N entries through the single memory
//    read port, one per cycle.
//  - The next request is taken as soon as the sequencer is idle, even while
//    the previous result still sits in the output register.
//  - If the receiver stalls, the finished result waits in the sequencer
//    until the output register frees up; no result is dropped.
//  - Synchronous active-low reset empties the stack (min reads all ones, max
//    reads zero) and drops any pending result. Entry storage is not cleared.
// ----------------------------------------------------------------------------
module stack_with_min_max (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  smm_pkg::t_in_item  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output smm_pkg::t_out_item o_out_res
);
    import smm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: handshakes and step order
    smm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // storage, extremes tracking, rescan and result register
    smm_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_out_res)
    );

endmodule

// ===== sv/smm_ctrl.sv =====
// ----------------------------------------------------------------------------
// smm_ctrl
// Sequencer for the min/max stack: request capture, top read, rescan, result.
// ----------------------------------------------------------------------------
module smm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output smm_pkg::t_dp_cmd   o_cmd,
    input  smm_pkg::t_dp_stat  i_stat
);
    import smm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if ((i_stat.req == REQ_POP || i_stat.req == REQ_PEEK) && !i_stat.empty) begin
                    n_state = S_TOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TOP: begin
                o_cmd.take_top = 1'b1;
                if (i_stat.req == REQ_POP && i_stat.top_extreme) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_issue = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.scan_fin = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== sv/smm_dpath.sv =====
// ----------------------------------------------------------------------------
// smm_dpath
// Entry memory, fill count, min/max registers, rescan unit and result register.
// ----------------------------------------------------------------------------
module smm_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smm_pkg::t_in_item  i_req,
    input  smm_pkg::t_dp_cmd   i_cmd,
    output smm_pkg::t_dp_stat  o_stat,
    output smm_pkg::t_out_item o_res
);
    import smm_pkg::*;

    logic [VAL_W-1:0] r_mem [STACK_DEPTH];
    logic [VAL_W-1:0] r_rd_data;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    top_idx;
    logic             full;
    logic             mem_we;

    t_in_item         r_req,      n_req;
    logic [CW-1:0]    r_count,    n_count;
    logic [VAL_W-1:0] r_min,      n_min;
    logic [VAL_W-1:0] r_max,      n_max;
    t_status          r_status,   n_status;
    logic [VAL_W-1:0] r_rd_val,   n_rd_val;
    logic             r_need_min, n_need_min;
    logic             r_need_max, n_need_max;
    logic [CW-1:0]    r_scan_idx, n_scan_idx;
    logic             r_pend,     n_pend;
    logic [VAL_W-1:0] r_acc_min,  n_acc_min;
    logic [VAL_W-1:0] r_acc_max,  n_acc_max;
    t_out_item        r_out,      n_out;

    assign top_idx = r_count - CW'(1);
    assign full    = (r_count >= CW'(STACK_DEPTH));
    assign rd_addr = i_cmd.scan_issue ? r_scan_idx[AW-1:0] : top_idx[AW-1:0];
    assign mem_we  = i_cmd.exec && (r_req.req_type == REQ_PUSH) && !full;

    // one write port and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= r_req.push_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stat.req         = r_req.req_type;
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.top_extreme = (r_rd_data == r_min) || (r_rd_data == r_max);
    assign o_stat.scan_more   = (r_scan_idx < r_count);

    always_comb begin
        n_req      = r_req;
        n_count    = r_count;
        n_min      = r_min;
        n_max      = r_max;
        n_status   = r_status;
        n_rd_val   = r_rd_val;
        n_need_min = r_need_min;
        n_need_max = r_need_max;
        n_scan_idx = r_scan_idx;
        n_acc_min  = r_acc_min;
        n_acc_max  = r_acc_max;
        n_out      = r_out;
        n_pend     = i_cmd.scan_issue;

        if (i_cmd.capture) begin
            n_req = i_req;
        end

        if (i_cmd.exec) begin
            n_rd_val = '0;
            n_status = ST_OK;
            case (r_req.req_type)
                REQ_PUSH: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                        if (r_req.push_value < r_min) begin
                            n_min = r_req.push_value;
                        end
                        if (r_req.push_value > r_max) begin
                            n_max = r_req.push_value;
                        end
                    end
                end
                REQ_CLEAR: begin
                    n_count = '0;
                    n_min   = EMPTY_MIN;
                    n_max   = EMPTY_MAX;
                end
                default: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end
                end
            endcase
        end

        if (i_cmd.take_top) begin
            n_rd_val = r_rd_data;
            if (r_req.req_type == REQ_POP) begin
                n_count    = top_idx;
                n_need_min = (r_rd_data == r_min);
                n_need_max = (r_rd_data == r_max);
                n_acc_min  = EMPTY_MIN;
                n_acc_max  = EMPTY_MAX;
                n_scan_idx = '0;
            end
        end

        if (i_cmd.scan_issue) begin
            n_scan_idx = r_scan_idx + CW'(1);
        end

        // data from the previous scan read
        if (r_pend) begin
            if (r_rd_data < r_acc_min) begin
                n_acc_min = r_rd_data;
            end
            if (r_rd_data > r_acc_max) begin
                n_acc_max = r_rd_data;
            end
        end

        if (i_cmd.scan_fin) begin
            if (r_need_min) begin
                n_min = r_acc_min;
            end
            if (r_need_max) begin
                n_max = r_acc_max;
            end
        end

        if (i_cmd.out_load) begin
            n_out.status     = r_status;
            n_out.read_value = r_rd_val;
            n_out.fill_count = f_fill(r_count);
            n_out.min_value  = r_min;
            n_out.max_value  = r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= EMPTY_MIN;
            r_max   <= EMPTY_MAX;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_status   <= n_status;
        r_rd_val   <= n_rd_val;
        r_need_min <= n_need_min;
        r_need_max <= n_need_max;
        r_scan_idx <= n_scan_idx;
        r_acc_min  <= n_acc_min;
        r_acc_max  <= n_acc_max;
        r_out      <= n_out;
    end

    assign o_res = r_out;

endmodule
